FILE: src/cdbm_pkg.sv
// Shared constants, types and helpers for the color dominance blob moments block.
`timescale 1ns / 1ps

package cdbm_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W   = 8;
    localparam int THR_W   = 9;
    localparam int DIM_W   = 12;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int CNT_W   = 23;
    localparam int SUM_W   = 33;
    localparam int NCOLOR  = 3;
    localparam int CFGI_W  = 2;

    localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

    localparam logic signed [THR_W-1:0] THRESHOLD_RST = THR_W'(60);
    localparam logic [DIM_W-1:0]        WIDTH_RST     = DIM_W'(640);
    localparam logic [DIM_W-1:0]        HEIGHT_RST    = DIM_W'(480);

    typedef enum logic [CFGI_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_MASK  = 2'd0,
        KIND_BLUE  = 2'd1,
        KIND_GREEN = 2'd2,
        KIND_RED   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sx;
        logic [SUM_W-1:0] sy;
    } t_totals;

    // Channel minus floor of the mean of the other two, compared to the margin.
    function automatic logic dominates(
        input logic [PIX_W-1:0]        self_v,
        input logic [PIX_W-1:0]        a_v,
        input logic [PIX_W-1:0]        b_v,
        input logic signed [THR_W-1:0] thr
    );
        logic [PIX_W:0]          pair_sum;
        logic signed [PIX_W+1:0] diff;
        pair_sum = {1'b0, a_v} + {1'b0, b_v};
        diff     = $signed({2'b00, self_v}) - $signed({2'b00, pair_sum[PIX_W:1]});
        return diff > (PIX_W+2)'(thr);
    endfunction

    // Clamp a frame dimension to 1..limit.
    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] limit
    );
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > limit) begin
            return limit;
        end else begin
            return v;
        end
    endfunction

endpackage

FILE: src/color_dominance_blob_moments.sv
// Color dominance segmentation with per-color pixel counts and coordinate sums.
//
//  channel   valid          ready          payload
//  pixel in  i_valid        o_ready        i_pixel_blue, i_pixel_green, i_pixel_red
//  result    o_valid        i_ready        o_record_kind .. o_last_of_run
//  config    i_cfg_valid    o_cfg_ready    i_cfg_index, i_cfg_data
//
// One pixel per clock when not stalled: input register, mask and accumulate
// logic, result register. A pixel's mask record moves from the input register
// to the result register once that is free. The last pixel of a frame adds
// three totals records; the input register holds while they are emitted.
// A low i_ready holds the result register and backs up into o_ready.
// Reset (synchronous, i_rst_n low) clears counters, accumulators and valids and
// restores the register defaults.
`timescale 1ns / 1ps

module color_dominance_blob_moments
    import cdbm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [PIX_W-1:0]        i_pixel_blue,
    input  logic [PIX_W-1:0]        i_pixel_green,
    input  logic [PIX_W-1:0]        i_pixel_red,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_record_kind,
    output logic                    o_blue_on,
    output logic                    o_green_on,
    output logic                    o_red_on,
    output logic [CNT_W-1:0]        o_pixel_count,
    output logic [SUM_W-1:0]        o_sum_x,
    output logic [SUM_W-1:0]        o_sum_y,
    output logic                    o_last_of_run,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFGI_W-1:0]       i_cfg_index,
    input  logic [DIM_W-1:0]        i_cfg_data
);

    // configuration
    logic signed [THR_W-1:0] r_threshold;
    logic [DIM_W-1:0]        r_width;
    logic [DIM_W-1:0]        r_height;

    // input register
    logic                    r_s1_valid;
    logic [PIX_W-1:0]        r_blue;
    logic [PIX_W-1:0]        r_green;
    logic [PIX_W-1:0]        r_red;

    // position and accumulators
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    t_totals                 r_acc  [NCOLOR];
    t_totals                 n_acc  [NCOLOR];
    t_totals                 r_snap [NCOLOR];
    logic [1:0]              r_tot_left;

    // result register
    logic                    r_out_valid;
    t_kind                   r_kind;
    logic                    r_bon;
    logic                    r_gon;
    logic                    r_ron;
    t_totals                 r_out;
    logic                    r_last;

    logic                    bon;
    logic                    gon;
    logic                    ron;
    logic [NCOLOR-1:0]       sel;
    logic [DIM_W-1:0]        w_eff;
    logic [DIM_W-1:0]        h_eff;
    logic                    row_end;
    logic                    frame_end;
    logic                    out_free;
    logic                    tot_emit;
    logic                    s1_adv;
    t_kind                   tot_kind;

    assign o_cfg_ready = 1'b1;

    assign bon = dominates(r_blue, r_red, r_green, r_threshold);
    assign gon = dominates(r_green, r_red, r_blue, r_threshold);
    assign ron = dominates(r_red, r_green, r_blue, r_threshold);
    assign sel = {ron & ~gon & ~bon, gon & ~bon, bon};

    assign w_eff     = clamp_dim(r_width, WIDTH_MAX);
    assign h_eff     = clamp_dim(r_height, HEIGHT_MAX);
    assign row_end   = DIM_W'(r_col) >= (w_eff - DIM_W'(1));
    assign frame_end = row_end && (DIM_W'(r_row) >= (h_eff - DIM_W'(1)));

    assign out_free = !r_out_valid || i_ready;
    assign tot_emit = out_free && (r_tot_left != 2'd0);
    assign s1_adv   = out_free && (r_tot_left == 2'd0) && r_s1_valid;
    assign o_ready  = !r_s1_valid || s1_adv;

    always_comb begin
        unique case (r_tot_left)
            2'd3:    tot_kind = KIND_BLUE;
            2'd2:    tot_kind = KIND_GREEN;
            2'd1:    tot_kind = KIND_RED;
            default: tot_kind = KIND_MASK;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NCOLOR; i++) begin
            n_acc[i] = r_acc[i];
            if (sel[i]) begin
                n_acc[i].cnt = r_acc[i].cnt + CNT_W'(1);
                n_acc[i].sx  = r_acc[i].sx + SUM_W'(r_col);
                n_acc[i].sy  = r_acc[i].sy + SUM_W'(r_row);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                CFG_WIDTH:     r_width     <= i_cfg_data;
                CFG_HEIGHT:    r_height    <= i_cfg_data;
                CFG_UNUSED:    ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_blue  <= i_pixel_blue;
            r_green <= i_pixel_green;
            r_red   <= i_pixel_red;
        end
    end

    // position, accumulators and frame-end snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_tot_left <= 2'd0;
            for (int i = 0; i < NCOLOR; i++) begin
                r_acc[i] <= '0;
            end
        end else if (s1_adv) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
            for (int i = 0; i < NCOLOR; i++) begin
                r_acc[i] <= frame_end ? '0 : n_acc[i];
            end
            if (frame_end) begin
                r_tot_left <= 2'd3;
            end
        end else if (tot_emit) begin
            r_tot_left <= r_tot_left - 2'd1;
        end
        if (s1_adv && frame_end) begin
            for (int i = 0; i < NCOLOR; i++) begin
                r_snap[i] <= n_acc[i];
            end
        end else if (tot_emit) begin
            // advance the totals queue
            r_snap[0] <= r_snap[1];
            r_snap[1] <= r_snap[2];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= tot_emit || s1_adv;
        end
        if (tot_emit) begin
            r_kind <= tot_kind;
            r_bon  <= 1'b0;
            r_gon  <= 1'b0;
            r_ron  <= 1'b0;
            r_out  <= r_snap[0];
            r_last <= (r_tot_left == 2'd1);
        end else if (s1_adv) begin
            r_kind <= KIND_MASK;
            r_bon  <= bon;
            r_gon  <= gon;
            r_ron  <= ron;
            r_out  <= '0;
            r_last <= !frame_end;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_record_kind = r_kind;
    assign o_blue_on     = r_bon;
    assign o_green_on    = r_gon;
    assign o_red_on      = r_ron;
    assign o_pixel_count = r_out.cnt;
    assign o_sum_x       = r_out.sx;
    assign o_sum_y       = r_out.sy;
    assign o_last_of_run = r_last;

    a_mask_then_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_record_kind == KIND_MASK) && !o_last_of_run
        |=> o_valid && (o_record_kind == KIND_BLUE))
        else $error("frame-end mask record not followed by blue totals");

    a_blue_then_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_record_kind == KIND_BLUE)
        |=> o_valid && (o_record_kind == KIND_GREEN))
        else $error("blue totals not followed by green totals");

    a_totals_no_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_record_kind != KIND_MASK)
        |-> !o_blue_on && !o_green_on && !o_red_on)
        else $error("totals record carries mask bits");

    a_hold_during_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tot_left != 2'd0) |-> !s1_adv)
        else $error("pixel advanced while totals pending");

endmodule
